FILE: hw/rtl/cartridge_real_time_clock_core_defines.svh
// Assertion helpers for the clock core checker.
`ifndef CARTRIDGE_REAL_TIME_CLOCK_CORE_DEFINES_SVH
`define CARTRIDGE_REAL_TIME_CLOCK_CORE_DEFINES_SVH

// Same-cycle implication, ignored while in reset.
`define CRTC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while in reset.
`define CRTC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds through reset.
`define CRTC_ASSERT_ALWAYS_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/crtc_pkg.sv
package crtc_pkg;

    localparam int DAYS_PER_WRAP_DEF    = 365;
    localparam int TICKS_PER_SECOND_DEF = 60;

    localparam int SUBTICK_W = 6;
    localparam int SECONDS_W = 6;
    localparam int MINUTES_W = 6;
    localparam int HOURS_W   = 5;
    localparam int DAYS_W    = 9;

    localparam int SECONDS_PER_MINUTE = 60;
    localparam int MINUTES_PER_HOUR   = 60;
    localparam int HOURS_PER_DAY      = 24;

    localparam logic [7:0] MOD_SIXTY  = 8'd60;
    localparam logic [7:0] MOD_HOURS  = 8'd24;
    localparam logic [7:0] UNUSED_REG = 8'hff;

    localparam int LATCH_DEPTH = 8;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_LATCH = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    localparam logic [2:0] REG_SECONDS = 3'd0;
    localparam logic [2:0] REG_MINUTES = 3'd1;
    localparam logic [2:0] REG_HOURS   = 3'd2;
    localparam logic [2:0] REG_DAY_LO  = 3'd3;
    localparam logic [2:0] REG_DAY_HI  = 3'd4;

    typedef struct packed {
        logic [1:0] op;
        logic [3:0] reg_select;
        logic [7:0] data;
    } crtc_in_t;

    typedef struct packed {
        logic [7:0]           read_data;
        logic [SUBTICK_W-1:0] live_subtick;
        logic [SECONDS_W-1:0] live_seconds;
        logic [MINUTES_W-1:0] live_minutes;
        logic [HOURS_W-1:0]   live_hours;
        logic [DAYS_W-1:0]    live_days;
        logic                 halted;
        logic                 day_carry;
    } crtc_out_t;

    typedef struct packed {
        logic en;    // beat accepted this cycle
        logic step;  // carry in from the lower cell
        logic load;  // direct load from a register write
    } crtc_cell_ctrl_t;

    // Byte remainder by a constant: four compare-subtract steps cover values
    // below 16x the modulus.
    function automatic logic [7:0] crtc_mod_byte(input logic [7:0] value,
                                                 input logic [7:0] modulus);
        logic [9:0] rem;
        logic [9:0] trial;
        rem = {2'b00, value};
        for (int k = 3; k >= 0; k--) begin
            trial = {2'b00, modulus} << k;
            if (rem >= trial) begin
                rem = rem - trial;
            end
        end
        return rem[7:0];
    endfunction

endpackage

FILE: hw/rtl/crtc_cell.sv
module crtc_cell #(
    parameter int WIDTH   = crtc_pkg::SECONDS_W,
    parameter int MODULUS = crtc_pkg::SECONDS_PER_MINUTE
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  crtc_pkg::crtc_cell_ctrl_t ctrl,
    input  logic [WIDTH-1:0]         load_value,
    output logic                     carry_out,
    output logic [WIDTH-1:0]         count,
    output logic [WIDTH-1:0]         count_next
);
    import crtc_pkg::*;

    logic [WIDTH-1:0] count_reg;
    logic [WIDTH-1:0] sum;
    logic             wrap;

    // Increment wraps at WIDTH bits without carry; hitting MODULUS clears and carries.
    assign sum       = count_reg + WIDTH'(1);
    assign wrap      = ctrl.step && (sum == WIDTH'(MODULUS));
    assign carry_out = wrap;

    always_comb begin
        count_next = count_reg;
        if (ctrl.load) begin
            count_next = load_value;
        end else if (ctrl.step) begin
            count_next = wrap ? '0 : sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (ctrl.en) begin
            count_reg <= count_next;
        end
    end

    assign count = count_reg;

endmodule

FILE: hw/rtl/cartridge_real_time_clock_core.sv
// Latency: a result beat appears on m_ the cycle after its input beat is accepted.
// Throughput: one beat per cycle while s_ready is high; the tick carry ripples
// through the five counter cells (subtick, seconds, minutes, hours, days)
// within that cycle. s_ready stays high while the output register is empty or
// being drained. Synchronous active-low reset clears all counters, flags,
// latched registers and the output valid.
module cartridge_real_time_clock_core #(
    parameter int DAYS_PER_WRAP    = crtc_pkg::DAYS_PER_WRAP_DEF,
    parameter int TICKS_PER_SECOND = crtc_pkg::TICKS_PER_SECOND_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  crtc_pkg::crtc_in_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output crtc_pkg::crtc_out_t m_data
);
    import crtc_pkg::*;

    logic       fire;
    logic       tick_en;
    logic       latch_en;
    logic       write_en;
    logic [2:0] reg_index;
    logic       latch_rise;

    logic       m_valid_reg;
    crtc_out_t  m_data_reg;
    logic       latch_prev_reg;
    logic       halt_reg;
    logic       halt_next;
    logic       carry_reg;
    logic       carry_next;
    logic [7:0] latched_reg  [LATCH_DEPTH];
    logic [7:0] latched_next [LATCH_DEPTH];

    crtc_cell_ctrl_t sub_ctrl, sec_ctrl, min_ctrl, hour_ctrl, day_ctrl;
    logic sub_carry, sec_carry, min_carry, hour_carry, day_carry;

    logic [SUBTICK_W-1:0] sub_count, sub_next;
    logic [SECONDS_W-1:0] sec_count, sec_next, sec_load;
    logic [MINUTES_W-1:0] min_count, min_next, min_load;
    logic [HOURS_W-1:0]   hour_count, hour_next, hour_load;
    logic [DAYS_W-1:0]    day_count, day_next, day_load;
    logic [7:0]           mod60;
    logic [7:0]           mod24;

    assign s_ready = !m_valid_reg || m_ready;
    assign fire    = s_valid && s_ready;

    always_comb begin
        tick_en  = 1'b0;
        latch_en = 1'b0;
        write_en = 1'b0;
        unique case (s_data.op)
            OP_TICK:  tick_en  = fire && !halt_reg;
            OP_LATCH: latch_en = fire;
            OP_WRITE: write_en = fire && s_data.reg_select[3];
            default: ;
        endcase
    end

    assign reg_index  = s_data.reg_select[2:0];
    assign latch_rise = latch_en && s_data.data[0] && !latch_prev_reg;

    assign mod60     = crtc_mod_byte(s_data.data, MOD_SIXTY);
    assign mod24     = crtc_mod_byte(s_data.data, MOD_HOURS);
    assign sec_load  = mod60[SECONDS_W-1:0];
    assign min_load  = mod60[MINUTES_W-1:0];
    assign hour_load = mod24[HOURS_W-1:0];
    assign day_load  = (reg_index == REG_DAY_LO) ? {day_count[DAYS_W-1], s_data.data}
                                                  : {s_data.data[0], day_count[7:0]};

    // carry chain: each cell above subtick steps on the carry of its lower neighbor
    assign sub_ctrl  = '{en: fire, step: tick_en,    load: 1'b0};
    assign sec_ctrl  = '{en: fire, step: sub_carry,
                         load: write_en && (reg_index == REG_SECONDS)};
    assign min_ctrl  = '{en: fire, step: sec_carry,
                         load: write_en && (reg_index == REG_MINUTES)};
    assign hour_ctrl = '{en: fire, step: min_carry,
                         load: write_en && (reg_index == REG_HOURS)};
    assign day_ctrl  = '{en: fire, step: hour_carry,
                         load: write_en && (reg_index == REG_DAY_LO ||
                                            reg_index == REG_DAY_HI)};

    crtc_cell #(.WIDTH(SUBTICK_W), .MODULUS(TICKS_PER_SECOND)) u_subtick (
        .aclk, .aresetn, .ctrl(sub_ctrl), .load_value('0),
        .carry_out(sub_carry), .count(sub_count), .count_next(sub_next)
    );

    crtc_cell #(.WIDTH(SECONDS_W), .MODULUS(SECONDS_PER_MINUTE)) u_seconds (
        .aclk, .aresetn, .ctrl(sec_ctrl), .load_value(sec_load),
        .carry_out(sec_carry), .count(sec_count), .count_next(sec_next)
    );

    crtc_cell #(.WIDTH(MINUTES_W), .MODULUS(MINUTES_PER_HOUR)) u_minutes (
        .aclk, .aresetn, .ctrl(min_ctrl), .load_value(min_load),
        .carry_out(min_carry), .count(min_count), .count_next(min_next)
    );

    crtc_cell #(.WIDTH(HOURS_W), .MODULUS(HOURS_PER_DAY)) u_hours (
        .aclk, .aresetn, .ctrl(hour_ctrl), .load_value(hour_load),
        .carry_out(hour_carry), .count(hour_count), .count_next(hour_next)
    );

    crtc_cell #(.WIDTH(DAYS_W), .MODULUS(DAYS_PER_WRAP)) u_days (
        .aclk, .aresetn, .ctrl(day_ctrl), .load_value(day_load),
        .carry_out(day_carry), .count(day_count), .count_next(day_next)
    );

    always_comb begin
        halt_next  = halt_reg;
        carry_next = carry_reg || day_carry;
        if (write_en && reg_index == REG_DAY_HI) begin
            halt_next  = s_data.data[6];
            carry_next = s_data.data[7];
        end
    end

    always_comb begin
        for (int i = 0; i < LATCH_DEPTH; i++) begin
            latched_next[i] = latched_reg[i];
        end
        if (latch_rise) begin
            latched_next[REG_SECONDS] = 8'(sec_count);
            latched_next[REG_MINUTES] = 8'(min_count);
            latched_next[REG_HOURS]   = 8'(hour_count);
            latched_next[REG_DAY_LO]  = day_count[7:0];
            latched_next[REG_DAY_HI]  = {carry_reg, halt_reg, 5'b00000, day_count[DAYS_W-1]};
            for (int i = REG_DAY_HI + 1; i < LATCH_DEPTH; i++) begin
                latched_next[i] = UNUSED_REG;
            end
        end else if (write_en && reg_index <= REG_DAY_HI) begin
            latched_next[reg_index] = s_data.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            latch_prev_reg <= 1'b0;
            halt_reg       <= 1'b0;
            carry_reg      <= 1'b0;
            for (int i = 0; i < LATCH_DEPTH; i++) begin
                latched_reg[i] <= '0;
            end
        end else if (fire) begin
            if (latch_en) begin
                latch_prev_reg <= s_data.data[0];
            end
            halt_reg    <= halt_next;
            carry_reg   <= carry_next;
            latched_reg <= latched_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_data_reg.read_data    <= latched_next[reg_index];
            m_data_reg.live_subtick <= sub_next;
            m_data_reg.live_seconds <= sec_next;
            m_data_reg.live_minutes <= min_next;
            m_data_reg.live_hours   <= hour_next;
            m_data_reg.live_days    <= day_next;
            m_data_reg.halted       <= halt_next;
            m_data_reg.day_carry    <= carry_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: hw/rtl/crtc_checker.sv
`include "cartridge_real_time_clock_core_defines.svh"

module crtc_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input crtc_pkg::crtc_in_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input crtc_pkg::crtc_out_t m_data
);
    import crtc_pkg::*;

    // output register comes out of reset empty and ready
    `CRTC_ASSERT_ALWAYS_NEXT(a_reset_empty, !aresetn, !m_valid && s_ready, "output not empty after reset")

    // every accepted beat yields a result beat in the next cycle
    `CRTC_ASSERT_NEXT(a_accept_to_result, s_valid && s_ready, m_valid, "accepted beat produced no result")

    // a stalled result beat holds
    `CRTC_ASSERT_NEXT(a_stall_hold, m_valid && !m_ready, m_valid && $stable(m_data), "stalled result beat changed")

    // time-of-day fields stay reduced
    `CRTC_ASSERT_NOW(a_time_range, m_valid, m_data.live_seconds < 6'(SECONDS_PER_MINUTE) && m_data.live_minutes < 6'(MINUTES_PER_HOUR) && m_data.live_hours < 5'(HOURS_PER_DAY), "live time out of range")

endmodule

bind cartridge_real_time_clock_core crtc_checker u_crtc_checker (.*);

FILE: bench/tb_cartridge_real_time_clock_core.sv
module tb_cartridge_real_time_clock_core;
    timeunit 1ns;
    timeprecision 1ps;

    import crtc_pkg::*;

    localparam logic [1:0] OP_UNUSED      = 2'd3;
    localparam logic [2:0] REG_SPARE_LO   = 3'd5;
    localparam logic [2:0] REG_SPARE_HI   = 3'd7;
    localparam int         SEL_ENABLE_BIT = 3;
    localparam int         IDLE_LIMIT     = 4000;
    localparam int         REPORT_LIMIT   = 10;

    logic      aclk;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    crtc_in_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    crtc_out_t m_data;

    cartridge_real_time_clock_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Shadow copy of the clock state
    logic                 latch_prev_q = 1'b0;
    logic [7:0]           latch_file [LATCH_DEPTH] = '{default: 8'h00};
    logic [SUBTICK_W-1:0] sub_q   = '0;
    logic [SECONDS_W-1:0] sec_q   = '0;
    logic [MINUTES_W-1:0] min_q   = '0;
    logic [HOURS_W-1:0]   hr_q    = '0;
    logic [DAYS_W-1:0]    day_q   = '0;
    logic                 halt_q  = 1'b0;
    logic                 carry_q = 1'b0;

    crtc_out_t pending_readings [$];
    int        fault_count    = 0;
    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;
    int        ready_cycle    = 0;
    int        hold_end       = 0;
    int        idle_cycles    = 0;

    function crtc_out_t advance_clock(crtc_in_t beat);
        crtc_out_t res;
        logic [2:0] idx;
        idx = beat.reg_select[2:0];
        case (beat.op)
            OP_TICK: begin
                if (!halt_q) begin
                    sub_q = sub_q + 1'b1;
                    if (sub_q >= TICKS_PER_SECOND_DEF) begin
                        sub_q = '0;
                        sec_q = sec_q + 1'b1;
                        if (sec_q >= SECONDS_PER_MINUTE) begin
                            sec_q = '0;
                            min_q = min_q + 1'b1;
                            if (min_q >= MINUTES_PER_HOUR) begin
                                min_q = '0;
                                hr_q  = hr_q + 1'b1;
                                if (hr_q >= HOURS_PER_DAY) begin
                                    hr_q  = '0;
                                    day_q = day_q + 1'b1;  // 9-bit wrap
                                    if (day_q == DAYS_PER_WRAP_DEF) begin
                                        day_q   = '0;
                                        carry_q = 1'b1;
                                    end
                                end
                            end
                        end
                    end
                end
            end
            OP_LATCH: begin
                if (beat.data[0] && !latch_prev_q) begin
                    latch_file[REG_SECONDS] = 8'(sec_q);
                    latch_file[REG_MINUTES] = 8'(min_q);
                    latch_file[REG_HOURS]   = 8'(hr_q);
                    latch_file[REG_DAY_LO]  = day_q[7:0];
                    latch_file[REG_DAY_HI]  = {carry_q, halt_q, 5'b0, day_q[8]};
                    for (int k = REG_SPARE_LO; k <= REG_SPARE_HI; k++) begin
                        latch_file[k] = UNUSED_REG;
                    end
                end
                latch_prev_q = beat.data[0];
            end
            OP_WRITE: begin
                if (beat.reg_select[SEL_ENABLE_BIT]) begin
                    case (idx)
                        REG_SECONDS: begin
                            latch_file[idx] = beat.data;
                            sec_q = SECONDS_W'(beat.data % SECONDS_PER_MINUTE);
                        end
                        REG_MINUTES: begin
                            latch_file[idx] = beat.data;
                            min_q = MINUTES_W'(beat.data % MINUTES_PER_HOUR);
                        end
                        REG_HOURS: begin
                            latch_file[idx] = beat.data;
                            hr_q = HOURS_W'(beat.data % HOURS_PER_DAY);
                        end
                        REG_DAY_LO: begin
                            latch_file[idx] = beat.data;
                            day_q[7:0] = beat.data;
                        end
                        REG_DAY_HI: begin
                            latch_file[idx] = beat.data;
                            day_q[8] = beat.data[0];
                            halt_q   = beat.data[6];
                            carry_q  = beat.data[7];
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
        res.read_data    = latch_file[idx];
        res.live_subtick = sub_q;
        res.live_seconds = sec_q;
        res.live_minutes = min_q;
        res.live_hours   = hr_q;
        res.live_days    = day_q;
        res.halted       = halt_q;
        res.day_carry    = carry_q;
        return res;
    endfunction

    // Predict on input beats, check on output beats
    always @(posedge aclk) begin
        crtc_out_t want;
        if (aresetn && s_valid && s_ready) begin
            pending_readings.push_back(advance_clock(s_data));
        end
        if (aresetn && m_valid && m_ready) begin
            if (pending_readings.size() == 0) begin
                fault_count++;
                if (fault_count <= REPORT_LIMIT) begin
                    $display("unexpected result beat: rd=%0h days=%0d", m_data.read_data,
                             m_data.live_days);
                end
            end else begin
                want = pending_readings.pop_front();
                if (m_data.read_data    !== want.read_data    ||
                    m_data.live_subtick !== want.live_subtick ||
                    m_data.live_seconds !== want.live_seconds ||
                    m_data.live_minutes !== want.live_minutes ||
                    m_data.live_hours   !== want.live_hours   ||
                    m_data.live_days    !== want.live_days    ||
                    m_data.halted       !== want.halted       ||
                    m_data.day_carry    !== want.day_carry) begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT) begin
                        // fields: rd sub s m h d halt carry
                        $display("mismatch got %0h %0d %0d %0d %0d %0d %0b %0b",
                                 m_data.read_data, m_data.live_subtick, m_data.live_seconds,
                                 m_data.live_minutes, m_data.live_hours, m_data.live_days,
                                 m_data.halted, m_data.day_carry);
                        $display("  want %0h %0d %0d %0d %0d %0d %0b %0b",
                                 want.read_data, want.live_subtick, want.live_seconds,
                                 want.live_minutes, want.live_hours, want.live_days,
                                 want.halted, want.day_carry);
                    end
                end
            end
        end
    end

    // Receiver: random stalls, plus a forced hold-off window
    always @(posedge aclk) begin
        ready_cycle++;
        if (ready_cycle < hold_end) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("cartridge_real_time_clock_core verification failed");
            $finish;
        end
    end

    // Valid stays up after a beat; the next call either lowers it or replaces the payload.
    task automatic send_beat(input logic [1:0] op, input logic [3:0] sel, input logic [7:0] data);
        crtc_in_t beat;
        beat.op         = op;
        beat.reg_select = sel;
        beat.data       = data;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            s_data  <= crtc_in_t'($urandom);
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_ticks(input int count);
        for (int i = 0; i < count; i++) begin
            send_beat(OP_TICK, 4'($urandom_range(15)), 8'($urandom_range(255)));
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
        send_beat(OP_WRITE, {1'b1, idx}, data);
    endtask

    task automatic set_time(input logic [7:0] sec, input logic [7:0] min, input logic [7:0] hr,
                            input logic [8:0] day, input logic halt, input logic carry);
        write_reg(REG_SECONDS, sec);
        write_reg(REG_MINUTES, min);
        write_reg(REG_HOURS, hr);
        write_reg(REG_DAY_LO, day[7:0]);
        write_reg(REG_DAY_HI, {carry, halt, 5'b0, day[8]});
    endtask

    task automatic test_register_writes();
        write_reg(REG_SECONDS, 8'd59);
        write_reg(REG_SECONDS, 8'd60);
        write_reg(REG_MINUTES, 8'hff);
        write_reg(REG_HOURS, 8'd23);
        write_reg(REG_HOURS, 8'd24);
        write_reg(REG_DAY_LO, 8'hff);
        write_reg(REG_DAY_HI, 8'hc1);
        write_reg(REG_DAY_HI, 8'h00);
        // access disabled, spare indexes, unused opcode: nothing moves
        send_beat(OP_WRITE, {1'b0, REG_SECONDS}, 8'h3a);
        send_beat(OP_WRITE, {1'b0, REG_DAY_HI}, 8'hff);
        for (int k = REG_SPARE_LO; k <= REG_SPARE_HI; k++) begin
            write_reg(3'(k), 8'hff);
        end
        send_beat(OP_UNUSED, 4'hf, 8'hff);
        send_beat(OP_UNUSED, 4'h0, 8'h00);
    endtask

    task automatic test_latch_control();
        send_beat(OP_LATCH, 4'h0, 8'hfe);
        send_beat(OP_LATCH, 4'h1, 8'h01);
        write_reg(REG_MINUTES, 8'd17);
        send_beat(OP_LATCH, 4'h1, 8'h01);   // level held: no second capture
        send_beat(OP_LATCH, 4'h5, 8'hff);
        send_beat(OP_LATCH, 4'h6, 8'h00);
        send_beat(OP_LATCH, 4'h7, 8'hff);
        for (int k = 0; k < LATCH_DEPTH; k++) begin
            send_beat(OP_UNUSED, 4'(k), 8'h00);
        end
    endtask

    task automatic test_time_rollover();
        set_time(8'd59, 8'd59, 8'd23, 9'd364, 1'b0, 1'b0);
        send_ticks(TICKS_PER_SECOND_DEF + 1);
        send_beat(OP_LATCH, 4'h0, 8'h00);
        send_beat(OP_LATCH, 4'hc, 8'h01);
        // day above the wrap point runs to the top and wraps without carry
        set_time(8'd59, 8'd59, 8'd23, 9'd511, 1'b0, 1'b0);
        send_ticks(TICKS_PER_SECOND_DEF + 1);
    endtask

    task automatic test_halt();
        set_time(8'd59, 8'd59, 8'd23, 9'd364, 1'b1, 1'b1);
        send_ticks(TICKS_PER_SECOND_DEF + 2);
        send_beat(OP_LATCH, 4'h0, 8'h00);
        send_beat(OP_LATCH, 4'h4, 8'h01);
        write_reg(REG_DAY_HI, 8'h01);
        send_ticks(3);
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct, input int beats);
        int sent;
        int pick;
        logic [2:0] idx;
        logic [7:0] data;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        sent = 0;
        while (sent < beats) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                pick = $urandom_range(1, 70);
                send_ticks(pick);
                sent += pick;
            end else if (pick < 60) begin
                send_beat(OP_LATCH, 4'($urandom_range(15)), 8'($urandom_range(255)));
                sent++;
            end else if (pick < 75) begin
                // preset near a boundary, for later ticks to carry through
                set_time(($urandom_range(2) != 0) ? 8'd59 : 8'($urandom_range(255)),
                         ($urandom_range(2) != 0) ? 8'd59 : 8'($urandom_range(255)),
                         ($urandom_range(2) != 0) ? 8'd23 : 8'($urandom_range(255)),
                         ($urandom_range(1) != 0) ? 9'd364 : 9'($urandom_range(511)),
                         ($urandom_range(7) == 0), 1'($urandom_range(1)));
                sent += 5;
            end else if (pick < 92) begin
                idx  = 3'($urandom_range(REG_DAY_HI));
                data = 8'($urandom_range(255));
                if (idx == REG_DAY_HI) begin
                    data[6] = ($urandom_range(7) == 0);
                end
                write_reg(idx, data);
                sent++;
            end else begin
                pick = $urandom_range(2);
                if (pick == 0) begin
                    send_beat(OP_UNUSED, 4'($urandom_range(15)), 8'($urandom_range(255)));
                end else if (pick == 1) begin
                    send_beat(OP_WRITE, {1'b0, 3'($urandom_range(7))},
                              8'($urandom_range(255)));
                end else begin
                    write_reg(3'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                              8'($urandom_range(255)));
                end
                sent++;
            end
        end
    endtask

    task automatic test_output_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_end = ready_cycle + 80;
        send_ticks(24);
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_register_writes();
        test_latch_control();
        test_time_rollover();
        test_halt();
        test_random_traffic(0, 0, 210);
        test_random_traffic(85, 0, 210);
        test_random_traffic(0, 85, 210);
        test_random_traffic(10, 10, 210);
        test_output_backpressure();
        s_valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        if (fault_count == 0) begin
            $display("cartridge_real_time_clock_core verification clean");
        end else begin
            $display("cartridge_real_time_clock_core verification failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/crtc_pkg.sv
hw/rtl/crtc_cell.sv
hw/rtl/cartridge_real_time_clock_core.sv
hw/rtl/crtc_checker.sv
bench/tb_cartridge_real_time_clock_core.sv
